// ===== src/fxau_pkg.sv =====
// Shared types, opcodes and sizing constants of the fixed-point arithmetic unit.
package fxau_pkg;

    // Number of fraction bits of the raw format (Q24.8 by default)
    localparam int FRAC_BITS = 8;
    // Dividend width of the divider, one quotient bit per pipeline stage
    localparam int DIV_STEPS = 32 + FRAC_BITS;

    // Opcodes
    localparam logic [3:0] OP_ADD     = 4'd0;
    localparam logic [3:0] OP_SUB     = 4'd1;
    localparam logic [3:0] OP_MUL     = 4'd2;
    localparam logic [3:0] OP_DIV     = 4'd3;
    localparam logic [3:0] OP_GT      = 4'd4;
    localparam logic [3:0] OP_LT      = 4'd5;
    localparam logic [3:0] OP_GE      = 4'd6;
    localparam logic [3:0] OP_LE      = 4'd7;
    localparam logic [3:0] OP_EQ      = 4'd8;
    localparam logic [3:0] OP_NE      = 4'd9;
    localparam logic [3:0] OP_MIN     = 4'd10;
    localparam logic [3:0] OP_MAX     = 4'd11;
    localparam logic [3:0] OP_INC     = 4'd12;
    localparam logic [3:0] OP_DEC     = 4'd13;
    localparam logic [3:0] OP_TOINT   = 4'd14;
    localparam logic [3:0] OP_FROMINT = 4'd15;

    // Request payload
    typedef struct packed {
        logic [3:0]         kind;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } t_fx_req;

    // Response payload
    typedef struct packed {
        logic signed [31:0] value;
        logic               truth;
        logic               div_by_zero;
    } t_fx_rsp;

    // Per-item control and result that rides along the divider stages
    typedef struct packed {
        logic [3:0]         kind;
        logic signed [31:0] value;
        logic               truth;
        logic               dz;
        logic               qneg;
    } t_fx_side;

endpackage

// ===== src/fixed_point_arith_unit_top.sv =====
// Pipeline: an input stage, the divider (unrolled to one quotient bit per stage, DIV_STEPS
// stages for Q24.8) and an output register. Throughput: one request per cycle unless stalled.
// A stall at the output freezes every stage; bubbles are not squeezed out.
// Reset (synchronous, active low) clears the stage valid bits only; payload
// registers are left as they are.
module fixed_point_arith_unit_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  fxau_pkg::t_fx_req i_in_req,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output fxau_pkg::t_fx_rsp o_out_rsp
);
    import fxau_pkg::*;

    // pipeline advance: everything moves unless a finished response is held
    logic w_adv;

    // input stage registers
    logic               r_s0_valid;
    t_fx_side           r_s0_side;
    logic signed [63:0] r_s0_prod;
    logic [31:0]        r_s0_abs_a;
    logic [31:0]        r_s0_abs_b;

    t_fx_side           n_s0_side;
    logic signed [63:0] n_s0_prod;
    logic [31:0]        n_s0_abs_a;
    logic [31:0]        n_s0_abs_b;

    // divider stage registers, one quotient bit each
    logic                   r_dv_valid [DIV_STEPS];
    t_fx_side               r_dv_side  [DIV_STEPS];
    logic [31:0]            r_dv_rem   [DIV_STEPS];
    logic [DIV_STEPS-1:0]   r_dv_work  [DIV_STEPS];
    logic [31:0]            r_dv_den   [DIV_STEPS];

    t_fx_side               n_dv_side  [DIV_STEPS];
    logic [31:0]            n_dv_rem   [DIV_STEPS];
    logic [DIV_STEPS-1:0]   n_dv_work  [DIV_STEPS];

    // output register
    logic    r_out_valid;
    t_fx_rsp r_out_rsp;
    t_fx_rsp n_out_rsp;

    assign w_adv       = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !w_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

    // input stage: simple ops, comparisons, product, divider operand prep
    always_comb begin
        logic signed [31:0] a;
        logic signed [31:0] b;
        a = i_in_req.operand_a;
        b = i_in_req.operand_b;

        n_s0_side       = '0;
        n_s0_side.kind  = i_in_req.kind;
        n_s0_side.dz    = (i_in_req.kind == OP_DIV) && (b == 32'sd0);
        n_s0_side.qneg  = a[31] ^ b[31];

        case (i_in_req.kind)
            OP_ADD:     n_s0_side.value = a + b;
            OP_SUB:     n_s0_side.value = a - b;
            OP_GT:      n_s0_side.truth = (a > b);
            OP_LT:      n_s0_side.truth = (a < b);
            OP_GE:      n_s0_side.truth = (a >= b);
            OP_LE:      n_s0_side.truth = (a <= b);
            OP_EQ:      n_s0_side.truth = (a == b);
            OP_NE:      n_s0_side.truth = (a != b);
            OP_MIN:     n_s0_side.value = (a < b) ? a : b;
            OP_MAX:     n_s0_side.value = (a > b) ? a : b;
            OP_INC:     n_s0_side.value = a + 32'sd1;
            OP_DEC:     n_s0_side.value = a - 32'sd1;
            OP_TOINT:   n_s0_side.value = a >>> FRAC_BITS;
            OP_FROMINT: n_s0_side.value = a <<< FRAC_BITS;
            default:    n_s0_side.value = '0;  // mul and div finish later
        endcase

        // signed 32x32 product, full 64 bits
        n_s0_prod  = 64'(a) * 64'(b);
        // magnitudes; the most negative value maps to 2^31 as unsigned
        n_s0_abs_a = a[31] ? 32'(-a) : 32'(a);
        n_s0_abs_b = b[31] ? 32'(-b) : 32'(b);
    end

    // divider stages: restoring step, one quotient bit per stage
    always_comb begin
        for (int k = 0; k < DIV_STEPS; k++) begin
            t_fx_side             c_side;
            logic [31:0]          c_rem;
            logic [DIV_STEPS-1:0] c_work;
            logic [31:0]          c_den;
            logic [32:0]          shifted;
            logic [32:0]          diff;
            logic                 qbit;

            if (k == 0) begin
                c_side = r_s0_side;
                // product scaled back by the fraction width
                if (r_s0_side.kind == OP_MUL) begin
                    c_side.value = r_s0_prod[FRAC_BITS+31:FRAC_BITS];
                end
                c_rem  = '0;
                c_work = {r_s0_abs_a, {FRAC_BITS{1'b0}}};
                c_den  = r_s0_abs_b;
            end else begin
                c_side = r_dv_side[k-1];
                c_rem  = r_dv_rem[k-1];
                c_work = r_dv_work[k-1];
                c_den  = r_dv_den[k-1];
            end

            shifted = {c_rem, c_work[DIV_STEPS-1]};
            diff    = shifted - {1'b0, c_den};
            qbit    = (shifted >= {1'b0, c_den});

            n_dv_side[k] = c_side;
            n_dv_rem[k]  = qbit ? diff[31:0] : shifted[31:0];
            n_dv_work[k] = {c_work[DIV_STEPS-2:0], qbit};
        end
    end

    // output stage: apply quotient sign and pick the result
    always_comb begin
        t_fx_side    l_side;
        logic [31:0] q;
        l_side = r_dv_side[DIV_STEPS-1];
        q      = r_dv_work[DIV_STEPS-1][31:0];

        n_out_rsp             = '0;
        n_out_rsp.truth       = l_side.truth;
        n_out_rsp.div_by_zero = l_side.dz;
        if (l_side.kind == OP_DIV) begin
            if (!l_side.dz) begin
                n_out_rsp.value = l_side.qneg ? -$signed(q) : $signed(q);
            end
        end else begin
            n_out_rsp.value = l_side.value;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_dv_valid[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_s0_valid  <= i_in_valid;
            r_dv_valid[0] <= r_s0_valid;
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_dv_valid[k] <= r_dv_valid[k-1];
            end
            r_out_valid <= r_dv_valid[DIV_STEPS-1];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s0_side  <= n_s0_side;
            r_s0_prod  <= n_s0_prod;
            r_s0_abs_a <= n_s0_abs_a;
            r_s0_abs_b <= n_s0_abs_b;
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_dv_side[k] <= n_dv_side[k];
                r_dv_rem[k]  <= n_dv_rem[k];
                r_dv_work[k] <= n_dv_work[k];
            end
            r_dv_den[0] <= r_s0_abs_b;
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_dv_den[k] <= r_dv_den[k-1];
            end
            r_out_rsp <= n_out_rsp;
        end
    end

`ifndef SYNTHESIS
    // a divide by zero reports zero and no comparison outcome
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_rsp.div_by_zero) |-> (o_out_rsp.value == '0 && !o_out_rsp.truth))
        else $error("divide by zero response carries a value");

    // a true comparison never carries a value
    a_truth_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_rsp.truth) |-> (o_out_rsp.value == '0))
        else $error("comparison response carries a value");

    // a held response freezes the input side
    a_hold_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("request accepted while output is held");

    // an accepted request lands in the input stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(i_in_valid && !o_in_stall)) |-> r_s0_valid)
        else $error("accepted request lost at the input stage");
`endif

endmodule

// ===== bench/fixed_point_arith_unit_top_tb.sv =====
// Self-checking testbench: Q24.8 arithmetic unit against a behavioral predictor.
module fixed_point_arith_unit_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fxau_pkg::*;

    localparam int PIPE_LATENCY = 2 + DIV_STEPS;
    localparam int RAND_ITEMS   = 1800;
    localparam int CYCLE_LIMIT  = 400_000;

    // Expected responses and the checks against them
    class fxau_scoreboard;
        t_fx_rsp pending_rsp_q[$];
        int      n_errors;
        int      n_checked;
        int      n_dz;
        int      n_true;
        int      kind_count[16];

        // Behavioral result of one request
        function t_fx_rsp arith_result(t_fx_req r);
            logic signed [63:0] wa;
            logic signed [63:0] wb;
            logic signed [63:0] prod;
            logic signed [63:0] quo;
            t_fx_rsp            res;
            wa   = 64'(r.operand_a);
            wb   = 64'(r.operand_b);
            res  = '0;
            case (r.kind)
                OP_ADD:     res.value = r.operand_a + r.operand_b;
                OP_SUB:     res.value = r.operand_a - r.operand_b;
                OP_MUL: begin
                    prod      = (wa * wb) >>> FRAC_BITS;
                    res.value = prod[31:0];
                end
                OP_DIV: begin
                    if (wb == 0) begin
                        res.div_by_zero = 1'b1;
                    end else begin
                        quo       = (wa <<< FRAC_BITS) / wb;
                        res.value = quo[31:0];
                    end
                end
                OP_GT:      res.truth = (wa > wb);
                OP_LT:      res.truth = (wa < wb);
                OP_GE:      res.truth = (wa >= wb);
                OP_LE:      res.truth = (wa <= wb);
                OP_EQ:      res.truth = (wa == wb);
                OP_NE:      res.truth = (wa != wb);
                OP_MIN:     res.value = (wa < wb) ? r.operand_a : r.operand_b;
                OP_MAX:     res.value = (wa > wb) ? r.operand_a : r.operand_b;
                OP_INC:     res.value = r.operand_a + 32'sd1;
                OP_DEC:     res.value = r.operand_a - 32'sd1;
                OP_TOINT:   res.value = $signed(r.operand_a) >>> FRAC_BITS;
                OP_FROMINT: res.value = r.operand_a << FRAC_BITS;
                default:    res = '0;
            endcase
            return res;
        endfunction

        function void note_request(t_fx_req r);
            t_fx_rsp exp_rsp;
            exp_rsp = arith_result(r);
            kind_count[r.kind]++;
            if (exp_rsp.div_by_zero) n_dz++;
            if (exp_rsp.truth) n_true++;
            pending_rsp_q.push_back(exp_rsp);
        endfunction

        function void check_response(t_fx_rsp got);
            t_fx_rsp exp_rsp;
            if (pending_rsp_q.size() == 0) begin
                $display("%0t: response with none pending: value=%h truth=%b dz=%b",
                         $time, got.value, got.truth, got.div_by_zero);
                n_errors++;
                return;
            end
            exp_rsp = pending_rsp_q.pop_front();
            n_checked++;
            if (got.value !== exp_rsp.value) begin
                $display("%0t: value mismatch: expected %h, actual %h",
                         $time, exp_rsp.value, got.value);
                n_errors++;
            end
            if (got.truth !== exp_rsp.truth) begin
                $display("%0t: truth mismatch: expected %b, actual %b",
                         $time, exp_rsp.truth, got.truth);
                n_errors++;
            end
            if (got.div_by_zero !== exp_rsp.div_by_zero) begin
                $display("%0t: div_by_zero mismatch: expected %b, actual %b",
                         $time, exp_rsp.div_by_zero, got.div_by_zero);
                n_errors++;
            end
        endfunction
    endclass

    logic    i_clk;
    logic    i_rst_n;
    logic    i_in_valid;
    logic    o_in_stall;
    t_fx_req i_in_req;
    logic    o_out_valid;
    logic    i_out_stall;
    t_fx_rsp o_out_rsp;

    fxau_scoreboard sb;
    int             cycle_count;
    int             stall_mode;
    int             stall_left;

    fixed_point_arith_unit_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses pending",
                     cycle_count, sb.pending_rsp_q.size());
            $display("fixed_point_arith_unit_top_tb: FAIL");
            $finish;
        end
    end

    // Receiver back-pressure: random modes of no, light, periodic and heavy stalling
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 99) < 30);
            2:       i_out_stall <= (stall_left % 8 < 3);
            default: i_out_stall <= ($urandom_range(0, 99) < 75);
        endcase
    end

    // Response monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_response(o_out_rsp);
    end

    // Hold one request until the unit takes it
    task automatic send_req(t_fx_req r);
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(r);
    endtask

    task automatic idle_for(int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Stop sending until every pending response has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending_rsp_q.size() != 0) @(posedge i_clk);
    endtask

    // Operand mix: full range, small magnitudes, corner values, scaled values
    function automatic logic signed [31:0] rand_operand();
        int                 v;
        logic signed [31:0] w;
        case ($urandom_range(0, 3))
            0: w = $urandom;
            1: begin
                v = $urandom_range(0, 8191);
                w = v - 4096;
            end
            2: begin
                case ($urandom_range(0, 5))
                    0:       w = 32'sh7FFF_FFFF;
                    1:       w = 32'sh8000_0000;
                    2:       w = 32'sd0;
                    3:       w = -32'sd1;
                    4:       w = 32'sd1;
                    default: w = 32'sd256;
                endcase
            end
            default: begin
                w = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1) == 1) w = -w;
            end
        endcase
        return w;
    endfunction

    initial begin
        t_fx_req req;
        int      burst_left;
        int      min_kind;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_req    = '0;
        i_out_stall = 1'b0;
        stall_mode  = 0;
        stall_left  = 0;
        cycle_count = 0;
        sb          = new();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed corners: wraps, overflows, divide by zero, truncation, ties
        send_req('{OP_ADD,     32'sh7FFF_FFFF, 32'sd1});
        send_req('{OP_ADD,     32'sh8000_0000, 32'sh8000_0000});
        send_req('{OP_SUB,     32'sh8000_0000, 32'sd1});
        send_req('{OP_MUL,     32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
        send_req('{OP_MUL,     -32'sd384,      32'sd512});
        send_req('{OP_MUL,     -32'sd1,        32'sd1});
        send_req('{OP_DIV,     32'sd256,       32'sd0});
        send_req('{OP_DIV,     32'sh8000_0000, -32'sd1});
        send_req('{OP_DIV,     -32'sd256,      32'sd768});
        send_req('{OP_DIV,     32'sh7FFF_FFFF, 32'sd1});
        send_req('{OP_GT,      32'sh8000_0000, 32'sh7FFF_FFFF});
        send_req('{OP_LT,      32'sh8000_0000, 32'sh7FFF_FFFF});
        send_req('{OP_GE,      32'sd5,         32'sd5});
        send_req('{OP_LE,      32'sh7FFF_FFFF, 32'sh8000_0000});
        send_req('{OP_EQ,      -32'sd1,        -32'sd1});
        send_req('{OP_NE,      32'sd0,         32'sh8000_0000});
        send_req('{OP_MIN,     32'sh8000_0000, 32'sh7FFF_FFFF});
        send_req('{OP_MAX,     32'sh8000_0000, 32'sh7FFF_FFFF});
        send_req('{OP_INC,     32'sh7FFF_FFFF, -32'sd1});
        send_req('{OP_DEC,     32'sh8000_0000, 32'sd0});
        send_req('{OP_TOINT,   -32'sd1,        32'sd0});
        send_req('{OP_TOINT,   32'sh8000_0000, 32'sd0});
        send_req('{OP_FROMINT, 32'sh00FF_FFFF, 32'sd0});
        send_req('{OP_FROMINT, 32'sh8000_0001, -32'sd1});
        wait_drained();

        // Random traffic in bursts
        burst_left = $urandom_range(1, 40);
        for (int i = 0; i < RAND_ITEMS; i++) begin
            req.kind      = 4'($urandom_range(0, 15));
            req.operand_a = rand_operand();
            case ($urandom_range(0, 15))
                0:       req.operand_b = 32'sd0;
                1, 2:    req.operand_b = req.operand_a;
                default: req.operand_b = rand_operand();
            endcase
            send_req(req);
            if (i == RAND_ITEMS / 2) wait_drained();
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 40);
                idle_for(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
            end
        end

        // Drain, then watch for stray responses
        wait_drained();
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);

        min_kind = sb.kind_count[0];
        foreach (sb.kind_count[k]) if (sb.kind_count[k] < min_kind) min_kind = sb.kind_count[k];
        $display("Covered %0d responses over all 16 opcodes (fewest per opcode: %0d),",
                 sb.n_checked, min_kind);
        $display("  %0d divides by zero, %0d true comparisons, %0d mismatches",
                 sb.n_dz, sb.n_true, sb.n_errors);
        if (sb.n_errors == 0) begin
            $display("fixed_point_arith_unit_top_tb: PASS");
        end else begin
            $display("fixed_point_arith_unit_top_tb: FAIL");
        end
        $finish;
    end

endmodule
